[rtl/fsfe_pkg.sv]
// Shared types and codes for the framebuffer shape fill engine.
package fsfe_pkg;

  // Pixel word width (RGB565)
  localparam int PIXEL_W = 16;

  // Request function codes
  localparam logic [2:0] FUNC_SET_PIXEL   = 3'd0;
  localparam logic [2:0] FUNC_FILL_SCREEN = 3'd1;
  localparam logic [2:0] FUNC_FILL_RECT   = 3'd2;
  localparam logic [2:0] FUNC_FILL_CIRCLE = 3'd3;
  localparam logic [2:0] FUNC_TICK        = 3'd4;

  // Result kind codes
  localparam logic [1:0] KIND_ANNOUNCE = 2'd0;
  localparam logic [1:0] KIND_PIXEL    = 2'd1;
  localparam logic [1:0] KIND_REFUSED  = 2'd2;

  // Clipped window of a drawing request
  typedef struct packed {
    logic       nonempty;
    logic [7:0] col_first;
    logic [7:0] col_last;
    logic [7:0] row_first;
    logic [7:0] row_last;
  } win_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL_ALL,
    ST_FILL_BOX,
    ST_READ
  } state_t;

endpackage

[rtl/fsfe_if.sv]
// Request and result channel interfaces of the shape fill engine.
interface fsfe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] color;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [7:0]  extent_w;
  logic [7:0]  extent_h;
  logic [6:0]  radius;

  modport source (
    output valid, func, color, pos_x, pos_y, extent_w, extent_h, radius,
    input  ready
  );
  modport sink (
    input  valid, func, color, pos_x, pos_y, extent_w, extent_h, radius,
    output ready
  );
endinterface

interface fsfe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  col_first;
  logic [7:0]  col_last;
  logic [6:0]  row_first;
  logic [6:0]  row_last;
  logic [15:0] pixel_color;
  logic        last;

  modport source (
    output valid, kind, col_first, col_last, row_first, row_last, pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, kind, col_first, col_last, row_first, row_last, pixel_color, last,
    output ready
  );
endinterface

[rtl/fsfe_store.sv]
// Frame store: single write port, single registered read port.
module fsfe_store #(
  parameter int DEPTH = 20480
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [fsfe_pkg::PIXEL_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [fsfe_pkg::PIXEL_W-1:0]  rd_data
);

  logic [fsfe_pkg::PIXEL_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/fsfe_clip.sv]
// Window computation: shape bounding box clipped to the screen.
module fsfe_clip #(
  parameter int SCREEN_COLS = 160,
  parameter int SCREEN_ROWS = 128
) (
  input  logic [2:0]     func,
  input  logic [7:0]     pos_x,
  input  logic [7:0]     pos_y,
  input  logic [7:0]     extent_w,
  input  logic [7:0]     extent_h,
  input  logic [6:0]     radius,
  output fsfe_pkg::win_t win
);

  localparam logic signed [9:0] COL_MAX = 10'(SCREEN_COLS - 1);
  localparam logic signed [9:0] ROW_MAX = 10'(SCREEN_ROWS - 1);

  logic signed [9:0] px, py, ew, eh, rad;
  logic signed [9:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [9:0] lo_xc, hi_xc, lo_yc, hi_yc;
  logic              shape_ok;

  assign px  = $signed({2'b00, pos_x});
  assign py  = $signed({2'b00, pos_y});
  assign ew  = $signed({2'b00, extent_w});
  assign eh  = $signed({2'b00, extent_h});
  assign rad = $signed({3'b000, radius});

  // Unclipped box per shape
  always_comb begin
    lo_x     = px;
    hi_x     = px;
    lo_y     = py;
    hi_y     = py;
    shape_ok = 1'b0;
    case (func)
      fsfe_pkg::FUNC_SET_PIXEL: begin
        shape_ok = 1'b1;
      end
      fsfe_pkg::FUNC_FILL_SCREEN: begin
        lo_x     = '0;
        hi_x     = COL_MAX;
        lo_y     = '0;
        hi_y     = ROW_MAX;
        shape_ok = 1'b1;
      end
      fsfe_pkg::FUNC_FILL_RECT: begin
        hi_x     = px + ew - 10'sd1;
        hi_y     = py + eh - 10'sd1;
        shape_ok = (extent_w != '0) && (extent_h != '0);
      end
      fsfe_pkg::FUNC_FILL_CIRCLE: begin
        lo_x     = px - rad;
        hi_x     = px + rad - 10'sd1;
        lo_y     = py - rad;
        hi_y     = py + rad - 10'sd1;
        shape_ok = (radius != '0);
      end
      default: begin
        shape_ok = 1'b0;
      end
    endcase
  end

  // Clip to the screen
  assign lo_xc = (lo_x < 10'sd0) ? 10'sd0 : lo_x;
  assign hi_xc = (hi_x > COL_MAX) ? COL_MAX : hi_x;
  assign lo_yc = (lo_y < 10'sd0) ? 10'sd0 : lo_y;
  assign hi_yc = (hi_y > ROW_MAX) ? ROW_MAX : hi_y;

  assign win.nonempty  = shape_ok && (lo_xc <= hi_xc) && (lo_yc <= hi_yc);
  assign win.col_first = lo_xc[7:0];
  assign win.col_last  = hi_xc[7:0];
  assign win.row_first = lo_yc[7:0];
  assign win.row_last  = hi_yc[7:0];

endmodule

[rtl/fsfe_ctrl.sv]
// Sequencer: clear pass, fill sweeps, readout scan and result register.
module fsfe_ctrl #(
  parameter int SCREEN_COLS = 160,
  parameter int SCREEN_ROWS = 128
) (
  input  logic                                             clk,
  input  logic                                             rst,
  fsfe_in_if.sink                                          cmd,
  fsfe_out_if.source                                       rsp,
  input  fsfe_pkg::win_t                                   win,
  output logic                                             wr_en,
  output logic [$clog2(SCREEN_COLS*SCREEN_ROWS)-1:0]       wr_addr,
  output logic [fsfe_pkg::PIXEL_W-1:0]                     wr_data,
  output logic                                             rd_en,
  output logic [$clog2(SCREEN_COLS*SCREEN_ROWS)-1:0]       rd_addr,
  input  logic [fsfe_pkg::PIXEL_W-1:0]                     rd_data
);

  localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int RW    = $clog2(SCREEN_ROWS);

  fsfe_pkg::state_t state, state_next;

  logic [CW-1:0] win_l, win_l_next, win_r, win_r_next;
  logic [RW-1:0] win_t, win_t_next, win_b, win_b_next;
  logic [CW-1:0] scan_col, scan_col_next;
  logic [RW-1:0] scan_row, scan_row_next;
  logic          row_major, row_major_next;
  logic          pending, pending_next;
  logic          read_last, read_last_next;
  logic [CW-1:0] fx, fx_next;
  logic [RW-1:0] fy, fy_next;
  logic [AW-1:0] sweep_addr, sweep_addr_next;

  logic [fsfe_pkg::PIXEL_W-1:0] fill_color, fill_color_next;
  logic [7:0]    ctr_x, ctr_x_next;
  logic [7:0]    ctr_y, ctr_y_next;
  logic [13:0]   rad_sq, rad_sq_next;
  logic          circle, circle_next;

  logic          out_valid, out_valid_next;
  logic [1:0]    out_kind, out_kind_next;
  logic [7:0]    out_cf, out_cf_next, out_cl, out_cl_next;
  logic [6:0]    out_rf, out_rf_next, out_rl, out_rl_next;
  logic [15:0]   out_pix, out_pix_next;
  logic          out_last, out_last_next;

  logic          accept, is_cmd, is_tick, scan_end, hit;
  logic [8:0]    adx, ady;
  logic [15:0]   sq_x, sq_y;
  logic [16:0]   dist_sq;

  // Linear store address of a pixel
  function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] col,
                                               input logic [RW-1:0] row);
    pix_addr = AW'(row) * AW'(SCREEN_COLS) + AW'(col);
  endfunction

  assign cmd.ready = (state == fsfe_pkg::ST_IDLE) && (!out_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign is_tick   = (cmd.func == fsfe_pkg::FUNC_TICK);
  assign is_cmd    = (cmd.func < fsfe_pkg::FUNC_TICK);
  assign scan_end  = (scan_col == win_r) && (scan_row == win_b);

  // Circle membership test at the current sweep point
  always_comb begin
    adx = ({1'b0, 8'(fx)} >= {1'b0, ctr_x}) ? 9'({1'b0, 8'(fx)} - {1'b0, ctr_x})
                                            : 9'({1'b0, ctr_x} - {1'b0, 8'(fx)});
    ady = ({1'b0, 8'(fy)} >= {1'b0, ctr_y}) ? 9'({1'b0, 8'(fy)} - {1'b0, ctr_y})
                                            : 9'({1'b0, ctr_y} - {1'b0, 8'(fy)});
    sq_x    = {7'b0, adx} * {7'b0, adx};
    sq_y    = {7'b0, ady} * {7'b0, ady};
    dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
    hit     = !circle || (dist_sq <= {3'b000, rad_sq});
  end

  // Next state, store access and result register
  always_comb begin
    state_next      = state;
    win_l_next      = win_l;
    win_r_next      = win_r;
    win_t_next      = win_t;
    win_b_next      = win_b;
    scan_col_next   = scan_col;
    scan_row_next   = scan_row;
    row_major_next  = row_major;
    pending_next    = pending;
    read_last_next  = read_last;
    fx_next         = fx;
    fy_next         = fy;
    sweep_addr_next = sweep_addr;
    fill_color_next = fill_color;
    ctr_x_next      = ctr_x;
    ctr_y_next      = ctr_y;
    rad_sq_next     = rad_sq;
    circle_next     = circle;
    out_valid_next  = out_valid && !rsp.ready;
    out_kind_next   = out_kind;
    out_cf_next     = out_cf;
    out_cl_next     = out_cl;
    out_rf_next     = out_rf;
    out_rl_next     = out_rl;
    out_pix_next    = out_pix;
    out_last_next   = out_last;
    wr_en           = 1'b0;
    wr_addr         = sweep_addr;
    wr_data         = fill_color;
    rd_en           = 1'b0;
    rd_addr         = pix_addr(scan_col, scan_row);

    unique case (state)
      // Zero the store one entry per cycle after reset
      fsfe_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (sweep_addr == AW'(DEPTH - 1)) begin
          state_next = fsfe_pkg::ST_IDLE;
        end else begin
          sweep_addr_next = sweep_addr + AW'(1);
        end
      end

      fsfe_pkg::ST_IDLE: begin
        if (accept && is_tick && pending) begin
          // Issue readout and advance the scan position
          rd_en          = 1'b1;
          read_last_next = scan_end;
          state_next     = fsfe_pkg::ST_READ;
          if (scan_end) begin
            pending_next = 1'b0;
          end else if (row_major) begin
            if (scan_col == win_r) begin
              scan_col_next = win_l;
              scan_row_next = scan_row + RW'(1);
            end else begin
              scan_col_next = scan_col + CW'(1);
            end
          end else begin
            if (scan_row == win_b) begin
              scan_row_next = win_t;
              scan_col_next = scan_col + CW'(1);
            end else begin
              scan_row_next = scan_row + RW'(1);
            end
          end
        end else if (accept && is_cmd && pending) begin
          // Refuse drawing while a readout is open
          out_valid_next = 1'b1;
          out_kind_next  = fsfe_pkg::KIND_REFUSED;
          out_cf_next    = '0;
          out_cl_next    = '0;
          out_rf_next    = '0;
          out_rl_next    = '0;
          out_pix_next   = '0;
          out_last_next  = 1'b0;
        end else if (accept && is_cmd && win.nonempty) begin
          // Open the window and announce it
          out_valid_next  = 1'b1;
          out_kind_next   = fsfe_pkg::KIND_ANNOUNCE;
          out_cf_next     = win.col_first;
          out_cl_next     = win.col_last;
          out_rf_next     = 7'(win.row_first);
          out_rl_next     = 7'(win.row_last);
          out_pix_next    = '0;
          out_last_next   = 1'b0;
          win_l_next      = CW'(win.col_first);
          win_r_next      = CW'(win.col_last);
          win_t_next      = RW'(win.row_first);
          win_b_next      = RW'(win.row_last);
          scan_col_next   = CW'(win.col_first);
          scan_row_next   = RW'(win.row_first);
          row_major_next  = (cmd.func == fsfe_pkg::FUNC_FILL_SCREEN);
          pending_next    = 1'b1;
          fill_color_next = cmd.color;
          fx_next         = CW'(win.col_first);
          fy_next         = RW'(win.row_first);
          ctr_x_next      = cmd.pos_x;
          ctr_y_next      = cmd.pos_y;
          rad_sq_next     = {7'b0, cmd.radius} * {7'b0, cmd.radius};
          circle_next     = (cmd.func == fsfe_pkg::FUNC_FILL_CIRCLE);
          sweep_addr_next = '0;
          unique case (cmd.func)
            fsfe_pkg::FUNC_SET_PIXEL: begin
              wr_en   = 1'b1;
              wr_addr = pix_addr(CW'(cmd.pos_x), RW'(cmd.pos_y));
              wr_data = cmd.color;
            end
            fsfe_pkg::FUNC_FILL_SCREEN: begin
              state_next = fsfe_pkg::ST_FILL_ALL;
            end
            default: begin
              state_next = fsfe_pkg::ST_FILL_BOX;
            end
          endcase
        end
      end

      // Sweep the whole store with the fill color
      fsfe_pkg::ST_FILL_ALL: begin
        wr_en = 1'b1;
        if (sweep_addr == AW'(DEPTH - 1)) begin
          state_next = fsfe_pkg::ST_IDLE;
        end else begin
          sweep_addr_next = sweep_addr + AW'(1);
        end
      end

      // Sweep the clipped box, writing covered pixels
      fsfe_pkg::ST_FILL_BOX: begin
        wr_en   = hit;
        wr_addr = pix_addr(fx, fy);
        if (fy == win_b) begin
          fy_next = win_t;
          if (fx == win_r) begin
            state_next = fsfe_pkg::ST_IDLE;
          end else begin
            fx_next = fx + CW'(1);
          end
        end else begin
          fy_next = fy + RW'(1);
        end
      end

      // Capture read data into the result register
      fsfe_pkg::ST_READ: begin
        out_valid_next = 1'b1;
        out_kind_next  = fsfe_pkg::KIND_PIXEL;
        out_cf_next    = '0;
        out_cl_next    = '0;
        out_rf_next    = '0;
        out_rl_next    = '0;
        out_pix_next   = rd_data;
        out_last_next  = read_last;
        state_next     = fsfe_pkg::ST_IDLE;
      end

      default: begin
        state_next = fsfe_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsfe_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_l      <= '0;
      win_r      <= '0;
      win_t      <= '0;
      win_b      <= '0;
      scan_col   <= '0;
      scan_row   <= '0;
      row_major  <= 1'b0;
      pending    <= 1'b0;
      sweep_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      win_l      <= win_l_next;
      win_r      <= win_r_next;
      win_t      <= win_t_next;
      win_b      <= win_b_next;
      scan_col   <= scan_col_next;
      scan_row   <= scan_row_next;
      row_major  <= row_major_next;
      pending    <= pending_next;
      sweep_addr <= sweep_addr_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    read_last  <= read_last_next;
    fx         <= fx_next;
    fy         <= fy_next;
    fill_color <= fill_color_next;
    ctr_x      <= ctr_x_next;
    ctr_y      <= ctr_y_next;
    rad_sq     <= rad_sq_next;
    circle     <= circle_next;
    out_kind   <= out_kind_next;
    out_cf     <= out_cf_next;
    out_cl     <= out_cl_next;
    out_rf     <= out_rf_next;
    out_rl     <= out_rl_next;
    out_pix    <= out_pix_next;
    out_last   <= out_last_next;
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.col_first   = out_cf;
  assign rsp.col_last    = out_cl;
  assign rsp.row_first   = out_rf;
  assign rsp.row_last    = out_rl;
  assign rsp.pixel_color = out_pix;
  assign rsp.last        = out_last;

endmodule

[rtl/framebuffer_shape_fill_engine_top.sv]
// Top level of the framebuffer shape fill engine.
// Commands: a nonempty window is announced (a request during an open readout is refused) in
// the cycle after it is taken; set pixel writes as it is taken, rectangle and circle fills
// sweep the clipped box and a screen fill every entry, all by the single store write port.
// Ticks: in an open readout a tick returns the next pixel via the store read register, then
// the result register; no tick is taken until its pixel is captured. Reset: synchronous;
// then a clearing pass zeroes all SCREEN_COLS*SCREEN_ROWS entries; requests wait until done.
module framebuffer_shape_fill_engine_top #(
  parameter int SCREEN_COLS = 160,
  parameter int SCREEN_ROWS = 128
) (
  input  logic       clk,
  input  logic       rst,
  fsfe_in_if.sink    cmd,
  fsfe_out_if.source rsp
);

  localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(DEPTH);

  fsfe_pkg::win_t               win;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [fsfe_pkg::PIXEL_W-1:0] wr_data;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [fsfe_pkg::PIXEL_W-1:0] rd_data;

  fsfe_clip #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_clip (
    .func     (cmd.func),
    .pos_x    (cmd.pos_x),
    .pos_y    (cmd.pos_y),
    .extent_w (cmd.extent_w),
    .extent_h (cmd.extent_h),
    .radius   (cmd.radius),
    .win      (win)
  );

  fsfe_ctrl #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .win     (win),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fsfe_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

[rtl/fsfe_checker.sv]
// Port-level assertions for the shape fill engine, bound to the top level.
module fsfe_checker #(
  parameter int SCREEN_COLS = 160
) (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  kind,
  input logic [7:0]  col_first,
  input logic [7:0]  col_last,
  input logic [6:0]  row_first,
  input logic [6:0]  row_last,
  input logic [15:0] pixel_color,
  input logic        last
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable({kind, col_first, col_last,
      row_first, row_last, pixel_color, last}))
    else $error("result changed while stalled");

  // A new result follows a taken request
  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd_valid && cmd_ready) || $past(cmd_valid && cmd_ready, 2))
    else $error("result without a request");

  // Announce windows have ordered columns that lie on screen
  a_win_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == fsfe_pkg::KIND_ANNOUNCE |->
      col_first <= col_last && col_last <= 8'(SCREEN_COLS - 1))
    else $error("bad announce window");

  // Non-announce results carry no window, and among them only pixels carry last or a color
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind != fsfe_pkg::KIND_ANNOUNCE |->
      col_first == '0 && col_last == '0 && row_first == '0 && row_last == '0 &&
      (kind == fsfe_pkg::KIND_PIXEL || (!last && pixel_color == '0)))
    else $error("stray fields in result");

  // No request is taken at the first cycle after reset (clearing pass)
  a_clear_block: assert property (@(posedge clk)
    $fell(rst) |-> !cmd_ready)
    else $error("request taken during clearing pass");

endmodule

bind framebuffer_shape_fill_engine_top fsfe_checker #(
  .SCREEN_COLS (SCREEN_COLS)
) u_fsfe_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .kind        (rsp.kind),
  .col_first   (rsp.col_first),
  .col_last    (rsp.col_last),
  .row_first   (rsp.row_first),
  .row_last    (rsp.row_last),
  .pixel_color (rsp.pixel_color),
  .last        (rsp.last)
);
